FILE: rtl/ntp_pkg.sv
// ============================================================================
// ntp_pkg: shared types and constants of the triplanar normal texel packer
// Fixed-point widths, register indexes and the payload structs of both channels.
// ============================================================================
package ntp_pkg;

    // Fraction bits of the normal components (2^FRAC_BITS means 1.0).
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int IN_W   = 16;
    localparam int TH_W   = 15;
    localparam int BYTE_W = 8;
    localparam int BYTE_MAX = (1 << BYTE_W) - 1;

    // Saturated component, signed; wide enough for +-ONE and for v + ONE.
    localparam int SAT_W  = (FRAC_BITS + 3 > IN_W + 1) ? FRAC_BITS + 3 : IN_W + 1;
    // Magnitude of a saturated component and the excess over a threshold.
    localparam int AW     = FRAC_BITS + 1;
    localparam int CMP_W  = (AW > TH_W) ? AW : TH_W;
    localparam int SQ_W   = 2 * AW;
    localparam int WW     = 3 * AW;
    localparam int TW     = WW + 2;
    localparam int NW     = TW + BYTE_W;
    localparam int PROD_W = FRAC_BITS + 2 + BYTE_W;

    // One quotient bit is resolved per normalization stage.
    localparam int DIV_STEPS  = BYTE_W;
    // The byte rescale runs over fewer stages, several narrow steps each.
    localparam int FIX_STAGES = 4;
    localparam int FIX_PER    = DIV_STEPS / FIX_STAGES;
    localparam int SUM_W      = BYTE_W + 1;
    localparam int FN_W       = 2 * BYTE_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_XY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_Z  = CFG_IDX_W'(1);

    localparam logic [TH_W-1:0] THRESH_XY_RST = TH_W'(10500);
    localparam logic [TH_W-1:0] THRESH_Z_RST  = TH_W'(6924);

    typedef struct packed {
        logic signed [IN_W-1:0] norm_x;
        logic signed [IN_W-1:0] norm_y;
        logic signed [IN_W-1:0] norm_z;
    } ntp_in_t;

    typedef struct packed {
        logic [31:0] texel;
        logic        degenerate;
    } ntp_out_t;

endpackage

FILE: rtl/normal_triplanar_texel_pack.sv
// ============================================================================
// normal_triplanar_texel_pack: terrain normal to packed triplanar texel
// Saturates a Q1.14 normal, quantizes x and y to bytes and computes two
// normalized triplanar blend weights in a fully pipelined datapath.
// ============================================================================
//
// The s_ channel takes one surface normal per transfer (s_data.norm_x/y/z,
// signed Q1.14). The m_ channel returns one result per normal, in order:
// m_data.texel packs weight y, nx byte, ny byte and weight x, and
// m_data.degenerate is high when all three axis weights were zero.
// The cfg_ channel writes the two thresholds; cfg_ready is always high and
// writes are expected only while the pipeline is empty.
//
// Throughput is one normal per cycle unless the receiver stalls. From the input to
// m_valid there are three stages for saturation, squaring and cubing, one
// for the weight sum, eight for the restoring division (one quotient bit per
// stage), one for rounding, four for the byte rescale and the output register.
//
// Reset clears every valid bit and loads the threshold reset values.
// When the receiver stalls, the whole pipeline holds: s_ready follows
// m_ready while a result is waiting, so nothing is lost or repeated.
module normal_triplanar_texel_pack (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ntp_pkg::ntp_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ntp_pkg::ntp_out_t                 m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ntp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ntp_pkg::TH_W-1:0]          cfg_data
);

    localparam int AW     = ntp_pkg::AW;
    localparam int SAT_W  = ntp_pkg::SAT_W;
    localparam int CMP_W  = ntp_pkg::CMP_W;
    localparam int SQ_W   = ntp_pkg::SQ_W;
    localparam int WW     = ntp_pkg::WW;
    localparam int TW     = ntp_pkg::TW;
    localparam int NW     = ntp_pkg::NW;
    localparam int PROD_W = ntp_pkg::PROD_W;
    localparam int BW     = ntp_pkg::BYTE_W;
    localparam int DS     = ntp_pkg::DIV_STEPS;
    localparam int FS     = ntp_pkg::FIX_STAGES;
    localparam int FP     = ntp_pkg::FIX_PER;
    localparam int SUM_W  = ntp_pkg::SUM_W;
    localparam int FN_W   = ntp_pkg::FN_W;
    localparam int TH_W   = ntp_pkg::TH_W;
    localparam int FB     = ntp_pkg::FRAC_BITS;

    // Data that rides along the pipeline untouched once it is known.
    typedef struct packed {
        logic [BW-1:0] bx;
        logic [BW-1:0] by;
        logic          degen;
    } side_t;

    // ------------------------------------------------------------------
    // Arithmetic helpers for the first stage.
    // ------------------------------------------------------------------
    function automatic logic signed [SAT_W-1:0] sat_comp(input logic signed [ntp_pkg::IN_W-1:0] raw);
        logic signed [SAT_W-1:0] v;
        logic signed [SAT_W-1:0] one_s;
        v     = SAT_W'(raw);
        one_s = SAT_W'(ntp_pkg::ONE);
        if (v > one_s) begin
            v = one_s;
        end else if (v < -one_s) begin
            v = -one_s;
        end
        return v;
    endfunction

    function automatic logic [AW-1:0] abs_comp(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] m;
        m = (v < 0) ? -v : v;
        return AW'($unsigned(m));
    endfunction

    // Amount by which a magnitude exceeds its threshold, zero when it does not.
    function automatic logic [AW-1:0] excess(input logic [AW-1:0] a, input logic [TH_W-1:0] th);
        logic [CMP_W-1:0] ae;
        logic [CMP_W-1:0] te;
        ae = CMP_W'(a);
        te = CMP_W'(th);
        if (ae > te) begin
            return AW'(ae - te);
        end
        return '0;
    endfunction

    // floor((v + 1.0) * 255 / 2.0) in the input scale.
    function automatic logic [BW-1:0] comp_byte(input logic signed [SAT_W-1:0] v);
        logic [PROD_W-1:0] s;
        logic [PROD_W-1:0] p;
        s = PROD_W'($unsigned(v + SAT_W'(ntp_pkg::ONE)));
        p = s * PROD_W'(ntp_pkg::BYTE_MAX);
        return p[FB+BW:FB+1];
    endfunction

    // ------------------------------------------------------------------
    // Handshake and configuration.
    // ------------------------------------------------------------------
    logic            adv;
    logic            m_valid_reg;
    ntp_pkg::ntp_out_t m_data_reg;
    logic [TH_W-1:0] thresh_xy_reg;
    logic [TH_W-1:0] thresh_z_reg;

    // A global advance: every stage moves when the output is free or taken.
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_xy_reg <= ntp_pkg::THRESH_XY_RST;
            thresh_z_reg  <= ntp_pkg::THRESH_Z_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ntp_pkg::CFG_THRESH_XY: thresh_xy_reg <= cfg_data;
                ntp_pkg::CFG_THRESH_Z:  thresh_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage registers.
    // ------------------------------------------------------------------
    logic [2:0]     st_vld_reg;
    logic [AW-1:0]  st1_dx_reg, st1_dy_reg, st1_dz_reg;
    side_t          st1_side_reg, st2_side_reg, st3_side_reg;
    logic [AW-1:0]  st2_dx_reg, st2_dy_reg, st2_dz_reg;
    logic [SQ_W-1:0] st2_sx_reg, st2_sy_reg, st2_sz_reg;
    logic [WW-1:0]  st3_wx_reg, st3_wy_reg, st3_wz_reg;

    // Division chain: index 0 holds the weight sum stage, index k+1 the
    // result of quotient step k.
    logic [DS:0]     div_vld_reg;
    side_t           div_side_reg [0:DS];
    logic [TW-1:0]   div_b_reg    [0:DS];
    logic [NW-1:0]   div_rx_reg   [0:DS];
    logic [NW-1:0]   div_ry_reg   [0:DS];
    logic [BW-1:0]   div_qx_reg   [0:DS];
    logic [BW-1:0]   div_qy_reg   [0:DS];

    // Rescale chain: index 0 holds the rounded bytes, index j+1 the result
    // of rescale stage j.
    logic [FS:0]      fix_vld_reg;
    side_t            fix_side_reg [0:FS];
    logic [SUM_W-1:0] fix_s_reg    [0:FS-1];
    logic             fix_over_reg [0:FS];
    logic [BW-1:0]    fix_ox_reg   [0:FS];
    logic [BW-1:0]    fix_oy_reg   [0:FS];
    logic [FN_W-1:0]  fix_rx_reg   [0:FS];
    logic [FN_W-1:0]  fix_ry_reg   [0:FS];
    logic [BW-1:0]    fix_qx_reg   [0:FS];
    logic [BW-1:0]    fix_qy_reg   [0:FS];

    // ------------------------------------------------------------------
    // Stage 1: saturate, quantize x and y, take the excess over threshold.
    // ------------------------------------------------------------------
    logic signed [SAT_W-1:0] sat_x, sat_y, sat_z;
    logic [AW-1:0] st1_dx_next, st1_dy_next, st1_dz_next;
    side_t         st1_side_next;

    always_comb begin
        sat_x = sat_comp(s_data.norm_x);
        sat_y = sat_comp(s_data.norm_y);
        sat_z = sat_comp(s_data.norm_z);
        st1_dx_next = excess(abs_comp(sat_x), thresh_xy_reg);
        st1_dy_next = excess(abs_comp(sat_y), thresh_xy_reg);
        st1_dz_next = excess(abs_comp(sat_z), thresh_z_reg);
        st1_side_next.bx    = comp_byte(sat_x);
        st1_side_next.by    = comp_byte(sat_y);
        st1_side_next.degen = 1'b0;
    end

    // ------------------------------------------------------------------
    // Weight sum stage: the cubes are summed and each numerator is scaled
    // by 255. The 7^3 factor cancels in the normalization and is left out.
    // ------------------------------------------------------------------
    logic [TW-1:0] sum_next;
    side_t         sum_side_next;

    always_comb begin
        sum_next = TW'(st3_wx_reg) + TW'(st3_wy_reg) + TW'(st3_wz_reg);
        sum_side_next       = st3_side_reg;
        sum_side_next.degen = (sum_next == '0);
    end

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage. The quotient never
    // exceeds 255 because each weight is at most the sum.
    // ------------------------------------------------------------------
    logic [NW-1:0] div_bs    [0:DS-1];
    logic [NW-1:0] div_rx_next [0:DS-1];
    logic [NW-1:0] div_ry_next [0:DS-1];
    logic [BW-1:0] div_qx_next [0:DS-1];
    logic [BW-1:0] div_qy_next [0:DS-1];

    always_comb begin
        for (int k = 0; k < DS; k++) begin
            div_bs[k]      = NW'(div_b_reg[k]) << (DS - 1 - k);
            div_rx_next[k] = div_rx_reg[k];
            div_ry_next[k] = div_ry_reg[k];
            div_qx_next[k] = div_qx_reg[k];
            div_qy_next[k] = div_qy_reg[k];
            if (div_rx_reg[k] >= div_bs[k]) begin
                div_rx_next[k] = div_rx_reg[k] - div_bs[k];
                div_qx_next[k] = div_qx_reg[k] | (BW'(1) << (DS - 1 - k));
            end
            if (div_ry_reg[k] >= div_bs[k]) begin
                div_ry_next[k] = div_ry_reg[k] - div_bs[k];
                div_qy_next[k] = div_qy_reg[k] | (BW'(1) << (DS - 1 - k));
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounding: add one when twice the remainder reaches the divisor. Then
    // prepare the rescale for the case where the two bytes exceed 255.
    // ------------------------------------------------------------------
    logic [BW-1:0]    rnd_x, rnd_y;
    logic [SUM_W-1:0] rnd_sum;

    always_comb begin
        rnd_x = div_qx_reg[DS] + BW'(((NW + 1)'(div_rx_reg[DS]) << 1)
                                      >= (NW + 1)'(div_b_reg[DS]));
        rnd_y = div_qy_reg[DS] + BW'(((NW + 1)'(div_ry_reg[DS]) << 1)
                                      >= (NW + 1)'(div_b_reg[DS]));
        rnd_sum = SUM_W'(rnd_x) + SUM_W'(rnd_y);
    end

    // ------------------------------------------------------------------
    // Rescale: floor(q * 255 / sum), several narrow quotient steps a stage.
    // ------------------------------------------------------------------
    logic [FN_W-1:0] fix_rx_next [0:FS-1];
    logic [FN_W-1:0] fix_ry_next [0:FS-1];
    logic [BW-1:0]   fix_qx_next [0:FS-1];
    logic [BW-1:0]   fix_qy_next [0:FS-1];

    always_comb begin
        logic [FN_W-1:0] rx;
        logic [FN_W-1:0] ry;
        logic [FN_W-1:0] bs;
        logic [BW-1:0]   qx;
        logic [BW-1:0]   qy;
        for (int j = 0; j < FS; j++) begin
            rx = fix_rx_reg[j];
            ry = fix_ry_reg[j];
            qx = fix_qx_reg[j];
            qy = fix_qy_reg[j];
            for (int t = 0; t < FP; t++) begin
                bs = FN_W'(fix_s_reg[j]) << (DS - 1 - (j * FP + t));
                if (rx >= bs) begin
                    rx = rx - bs;
                    qx = qx | (BW'(1) << (DS - 1 - (j * FP + t)));
                end
                if (ry >= bs) begin
                    ry = ry - bs;
                    qy = qy | (BW'(1) << (DS - 1 - (j * FP + t)));
                end
            end
            fix_rx_next[j] = rx;
            fix_ry_next[j] = ry;
            fix_qx_next[j] = qx;
            fix_qy_next[j] = qy;
        end
    end

    // ------------------------------------------------------------------
    // Output selection: rescaled bytes when the sum overflowed, zero
    // weights for a degenerate normal.
    // ------------------------------------------------------------------
    logic [BW-1:0]     out_wx, out_wy;
    ntp_pkg::ntp_out_t out_next;

    always_comb begin
        out_wx = fix_over_reg[FS] ? fix_qx_reg[FS] : fix_ox_reg[FS];
        out_wy = fix_over_reg[FS] ? fix_qy_reg[FS] : fix_oy_reg[FS];
        if (fix_side_reg[FS].degen) begin
            out_wx = '0;
            out_wy = '0;
        end
        out_next.texel      = {out_wy, fix_side_reg[FS].bx, fix_side_reg[FS].by, out_wx};
        out_next.degenerate = fix_side_reg[FS].degen;
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data; they and the thresholds are the only reset state.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg  <= '0;
            div_vld_reg <= '0;
            fix_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            st_vld_reg  <= {st_vld_reg[1:0], s_valid};
            div_vld_reg <= {div_vld_reg[DS-1:0], st_vld_reg[2]};
            fix_vld_reg <= {fix_vld_reg[FS-1:0], div_vld_reg[DS]};
            m_valid_reg <= fix_vld_reg[FS];
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_dx_reg   <= st1_dx_next;
            st1_dy_reg   <= st1_dy_next;
            st1_dz_reg   <= st1_dz_next;
            st1_side_reg <= st1_side_next;

            st2_sx_reg   <= SQ_W'(st1_dx_reg) * SQ_W'(st1_dx_reg);
            st2_sy_reg   <= SQ_W'(st1_dy_reg) * SQ_W'(st1_dy_reg);
            st2_sz_reg   <= SQ_W'(st1_dz_reg) * SQ_W'(st1_dz_reg);
            st2_dx_reg   <= st1_dx_reg;
            st2_dy_reg   <= st1_dy_reg;
            st2_dz_reg   <= st1_dz_reg;
            st2_side_reg <= st1_side_reg;

            st3_wx_reg   <= WW'(st2_sx_reg) * WW'(st2_dx_reg);
            st3_wy_reg   <= WW'(st2_sy_reg) * WW'(st2_dy_reg);
            st3_wz_reg   <= WW'(st2_sz_reg) * WW'(st2_dz_reg);
            st3_side_reg <= st2_side_reg;

            div_side_reg[0] <= sum_side_next;
            div_b_reg[0]    <= sum_next;
            div_rx_reg[0]   <= (NW'(st3_wx_reg) << BW) - NW'(st3_wx_reg);
            div_ry_reg[0]   <= (NW'(st3_wy_reg) << BW) - NW'(st3_wy_reg);
            div_qx_reg[0]   <= '0;
            div_qy_reg[0]   <= '0;
            for (int k = 0; k < DS; k++) begin
                div_side_reg[k+1] <= div_side_reg[k];
                div_b_reg[k+1]    <= div_b_reg[k];
                div_rx_reg[k+1]   <= div_rx_next[k];
                div_ry_reg[k+1]   <= div_ry_next[k];
                div_qx_reg[k+1]   <= div_qx_next[k];
                div_qy_reg[k+1]   <= div_qy_next[k];
            end

            fix_side_reg[0] <= div_side_reg[DS];
            fix_s_reg[0]    <= rnd_sum;
            fix_over_reg[0] <= (rnd_sum > SUM_W'(ntp_pkg::BYTE_MAX));
            fix_ox_reg[0]   <= rnd_x;
            fix_oy_reg[0]   <= rnd_y;
            fix_rx_reg[0]   <= (FN_W'(rnd_x) << BW) - FN_W'(rnd_x);
            fix_ry_reg[0]   <= (FN_W'(rnd_y) << BW) - FN_W'(rnd_y);
            fix_qx_reg[0]   <= '0;
            fix_qy_reg[0]   <= '0;
            for (int j = 0; j < FS; j++) begin
                fix_side_reg[j+1] <= fix_side_reg[j];
                fix_over_reg[j+1] <= fix_over_reg[j];
                fix_ox_reg[j+1]   <= fix_ox_reg[j];
                fix_oy_reg[j+1]   <= fix_oy_reg[j];
                fix_rx_reg[j+1]   <= fix_rx_next[j];
                fix_ry_reg[j+1]   <= fix_ry_next[j];
                fix_qx_reg[j+1]   <= fix_qx_next[j];
                fix_qy_reg[j+1]   <= fix_qy_next[j];
            end
            for (int j = 0; j < FS - 1; j++) begin
                fix_s_reg[j+1] <= fix_s_reg[j];
            end

            m_data_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An accepted normal occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> st_vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    // A stall freezes the occupancy of the division and rescale chains.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(div_vld_reg) && $stable(fix_vld_reg))
        else $error("pipeline moved during a stall");

    // The long division leaves a remainder below the divisor.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        div_vld_reg[DS] && !div_side_reg[DS].degen
            |-> div_rx_reg[DS] < NW'(div_b_reg[DS]) && div_ry_reg[DS] < NW'(div_b_reg[DS]))
        else $error("division remainder not below divisor");

    // Delivered weights never sum above 255 and are zero when degenerate.
    a_out_weights: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (SUM_W'(m_data.texel[31:24]) + SUM_W'(m_data.texel[7:0])
                        <= SUM_W'(ntp_pkg::BYTE_MAX))
                 && (!m_data.degenerate
                     || (m_data.texel[31:24] == '0 && m_data.texel[7:0] == '0)))
        else $error("output weight bytes out of range");

endmodule
